// ===== src/lat_pkg.sv =====
// Package: shared constants, status codes and tables for the landmark association table.
`default_nettype none
package lat_pkg;

  localparam int unsigned LAT_CAPACITY   = 64;
  localparam int unsigned CORDIC_STEPS   = 24;
  localparam int unsigned ENTRY_W        = 104;
  localparam int unsigned ANG_W          = 34;
  localparam int unsigned DIV_W          = 34;
  localparam int unsigned PADDR_W        = 3;
  localparam logic [23:0] RADIUS_RESET   = 24'd10486;
  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629714;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef enum logic [1:0] {
    ST_MERGED   = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_SKIPPED  = 2'd3
  } status_e;

  function automatic logic [27:0] atan_q28(input logic [4:0] idx);
    logic [27:0] v;
    unique case (idx)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/lat_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module lat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/landmark_association_table_unit.sv =====
// Top level: landmark association table with CORDIC position, table scan and mean update.
//
// One item at a time: busy is high from acceptance until its result strobe;
// for an invalid or skipped item busy stays low and it answers in the next cycle.
// Any other item passes through the 24-step CORDIC, then a scan of the entries,
// each read from the single-port table RAM and then compared, squared and
// checked, and on a merge a 34-step divider for the mean.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none
module landmark_association_table_unit
  import lat_pkg::*;
#(
  parameter int unsigned CAPACITY = LAT_CAPACITY
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] robot_x_i,
  input  wire logic signed [31:0] robot_y_i,
  input  wire logic signed [15:0] robot_heading_i,
  input  wire logic        [23:0] distance_i,
  input  wire logic signed [15:0] bearing_i,
  input  wire logic        [7:0]  cone_label_i,
  input  wire logic               invalid_i,
  input  wire logic               last_of_batch_i,
  output logic                    result_valid_o,
  output logic        [1:0]       status_o,
  output logic        [5:0]       slot_o,
  output logic signed [31:0]      landmark_x_o,
  output logic signed [31:0]      landmark_y_o,
  output logic        [15:0]      sample_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_FOLD, S_ROTATE, S_MULC, S_MULS, S_POS,
    S_RD, S_CMP, S_SQ, S_CHK, S_DIV, S_MERGE, S_MISS
  } state_e;

  state_e state_q;
  logic skip_q;
  logic [UW-1:0] used_q, idx_q;
  logic [23:0] radius_q;
  logic signed [31:0] rx_q, ry_q, posx_q, posy_q, ex_q, ey_q;
  logic signed [15:0] head_q, eh_q;
  logic [23:0] dist_q;
  logic [7:0] label_q;
  logic [15:0] ecnt_q;
  logic signed [ANG_W-1:0] z_q, cx_q, cy_q;
  logic flip_q;
  logic [4:0] it_q;
  logic signed [58:0] px_q, py_q;
  logic signed [24:0] dx_q, dy_q;
  logic ok_q;
  logic [49:0] sum_q;
  logic [DIV_W-1:0] dvd_q [3];
  logic [16:0] rem_q [3];
  logic neg_q [3];
  logic [16:0] den_q;
  logic [5:0] dit_q;
  logic res_valid_q;
  logic [1:0] status_q;
  logic [5:0] slot_q;
  logic signed [31:0] lx_q, ly_q;
  logic [15:0] cnt_q;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic accept, cfg_we;
  logic signed [16:0] diff17;
  logic signed [ANG_W-1:0] z_init, sh_x, sh_y, atan_v, cos_v, sin_v, mul_op;
  logic signed [58:0] mul_res, p_sel, p_shr;
  logic signed [31:0] r_sel, pos_sat;
  logic signed [34:0] pos_sum;
  logic signed [31:0] rd_x, rd_y;
  logic signed [15:0] rd_h;
  logic [7:0] rd_lab;
  logic [15:0] rd_cnt;
  logic signed [32:0] dx33, dy33;
  logic inr_x, inr_y;
  logic signed [49:0] sq_x, sq_y;
  logic [16:0] den_n;
  logic signed [32:0] num_x, num_y;
  logic signed [16:0] num_h;
  logic [DIV_W-1:0] mag [3];
  logic neg_n [3];
  logic [17:0] trial [3];
  logic ge [3];
  logic signed [DIV_W-1:0] q_s [3];
  logic signed [DIV_W-1:0] new_x, new_y, new_h;
  logic [15:0] n_new;
  logic hit;

  assign pready = 1'b1;
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {8'd0, radius_q} : 32'd0;

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign landmark_x_o   = lx_q;
  assign landmark_y_o   = ly_q;
  assign sample_count_o = cnt_q;

  assign {rd_x, rd_y, rd_h, rd_lab, rd_cnt} = ram_rdata;

  always_comb begin
    diff17 = {robot_heading_i[15], robot_heading_i} - {bearing_i[15], bearing_i};
    z_init = {{2{diff17[16]}}, diff17, 15'd0};
    sh_x   = cx_q >>> it_q;
    sh_y   = cy_q >>> it_q;
    atan_v = {6'd0, atan_q28(it_q)};
    cos_v  = flip_q ? -cx_q : cx_q;
    sin_v  = flip_q ? -cy_q : cy_q;
    mul_op = (state_q == S_MULC) ? cos_v : sin_v;
    mul_res = $signed({1'b0, dist_q}) * mul_op;
    p_sel  = (state_q == S_MULS) ? px_q : py_q;
    r_sel  = (state_q == S_MULS) ? rx_q : ry_q;
    p_shr  = (p_sel + 59'sd536870912) >>> 30;
    pos_sum = {{3{r_sel[31]}}, r_sel} + p_shr[34:0];
    if (pos_sum[34:31] == 4'b0000 || pos_sum[34:31] == 4'b1111) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[34]) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'sh7FFF_FFFF;
    end

    dx33  = {posx_q[31], posx_q} - {rd_x[31], rd_x};
    dy33  = {posy_q[31], posy_q} - {rd_y[31], rd_y};
    inr_x = (dx33[32:24] == '0) || (dx33[32:24] == '1 && dx33[23:0] != '0);
    inr_y = (dy33[32:24] == '0) || (dy33[32:24] == '1 && dy33[23:0] != '0);
    sq_x  = dx_q * dx_q;
    sq_y  = dy_q * dy_q;
    hit   = ok_q && (sum_q < {10'd0, radius_q, 16'd0});

    den_n = {1'b0, ecnt_q} + 17'd1;
    num_x = {posx_q[31], posx_q} - {ex_q[31], ex_q};
    num_y = {posy_q[31], posy_q} - {ey_q[31], ey_q};
    num_h = {head_q[15], head_q} - {eh_q[15], eh_q};
    neg_n[0] = num_x[32];
    neg_n[1] = num_y[32];
    neg_n[2] = num_h[16];
    mag[0] = (num_x[32] ? DIV_W'(-num_x) : DIV_W'(num_x)) + DIV_W'(den_n[16:1]);
    mag[1] = (num_y[32] ? DIV_W'(-num_y) : DIV_W'(num_y)) + DIV_W'(den_n[16:1]);
    mag[2] = (num_h[16] ? DIV_W'(-num_h) : DIV_W'(num_h)) + DIV_W'(den_n[16:1]);
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], dvd_q[k][DIV_W-1]};
      ge[k]    = (trial[k] >= {1'b0, den_q});
      q_s[k]   = neg_q[k] ? -$signed(dvd_q[k]) : $signed(dvd_q[k]);
    end
    new_x = {{2{ex_q[31]}}, ex_q} + q_s[0];
    new_y = {{2{ey_q[31]}}, ey_q} + q_s[1];
    new_h = {{18{eh_q[15]}}, eh_q} + q_s[2];
    n_new = (ecnt_q == 16'hFFFF) ? ecnt_q : ecnt_q + 16'd1;

    ram_re    = (state_q == S_RD) && (idx_q < used_q);
    ram_we    = (state_q == S_MERGE) ||
                ((state_q == S_MISS) && (used_q < UW'(CAPACITY)));
    ram_addr  = (state_q == S_MISS) ? used_q[AW-1:0] : idx_q[AW-1:0];
    ram_wdata = (state_q == S_MERGE) ?
                {new_x[31:0], new_y[31:0], new_h[15:0], label_q, n_new} :
                {posx_q, posy_q, head_q, label_q, 16'd1};
  end

  lat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      skip_q      <= 1'b0;
      used_q      <= '0;
      idx_q       <= '0;
      radius_q    <= RADIUS_RESET;
      res_valid_q <= 1'b0;
      it_q        <= '0;
      dit_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we) begin
        radius_q <= pwdata[23:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (skip_q || invalid_i) begin
              skip_q      <= !last_of_batch_i;
              res_valid_q <= 1'b1;
              status_q    <= ST_SKIPPED;
              slot_q      <= '0;
              lx_q        <= '0;
              ly_q        <= '0;
              cnt_q       <= '0;
            end else begin
              rx_q    <= robot_x_i;
              ry_q    <= robot_y_i;
              head_q  <= robot_heading_i;
              dist_q  <= distance_i;
              label_q <= cone_label_i;
              z_q     <= z_init;
              state_q <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (z_q > PI_Q28) begin
            z_q <= z_q - TWO_PI_Q28;
          end else if (z_q < -PI_Q28) begin
            z_q <= z_q + TWO_PI_Q28;
          end
          state_q <= S_FOLD;
        end
        S_FOLD: begin
          flip_q <= 1'b0;
          if (z_q > HALF_PI_Q28) begin
            z_q    <= z_q - PI_Q28;
            flip_q <= 1'b1;
          end else if (z_q < -HALF_PI_Q28) begin
            z_q    <= z_q + PI_Q28;
            flip_q <= 1'b1;
          end
          cx_q    <= GAIN_Q30;
          cy_q    <= '0;
          it_q    <= '0;
          state_q <= S_ROTATE;
        end
        S_ROTATE: begin
          if (z_q >= 0) begin
            cx_q <= cx_q - sh_y;
            cy_q <= cy_q + sh_x;
            z_q  <= z_q - atan_v;
          end else begin
            cx_q <= cx_q + sh_y;
            cy_q <= cy_q - sh_x;
            z_q  <= z_q + atan_v;
          end
          it_q <= it_q + 5'd1;
          if (it_q == 5'(CORDIC_STEPS - 1)) begin
            state_q <= S_MULC;
          end
        end
        S_MULC: begin
          px_q    <= mul_res;
          state_q <= S_MULS;
        end
        S_MULS: begin
          py_q    <= mul_res;
          posx_q  <= pos_sat;
          state_q <= S_POS;
        end
        S_POS: begin
          posy_q  <= pos_sat;
          idx_q   <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= (idx_q < used_q) ? S_CMP : S_MISS;
        end
        S_CMP: begin
          ex_q    <= rd_x;
          ey_q    <= rd_y;
          eh_q    <= rd_h;
          ecnt_q  <= rd_cnt;
          dx_q    <= dx33[24:0];
          dy_q    <= dy33[24:0];
          ok_q    <= (rd_lab == label_q) && inr_x && inr_y;
          state_q <= S_SQ;
        end
        S_SQ: begin
          sum_q   <= 50'(sq_x) + 50'(sq_y);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            den_q <= den_n;
            for (int k = 0; k < 3; k++) begin
              dvd_q[k] <= mag[k];
              rem_q[k] <= '0;
              neg_q[k] <= neg_n[k];
            end
            dit_q   <= '0;
            state_q <= S_DIV;
          end else begin
            idx_q   <= idx_q + UW'(1);
            state_q <= S_RD;
          end
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem_q[k] <= ge[k] ? 17'(trial[k] - {1'b0, den_q}) : trial[k][16:0];
            dvd_q[k] <= {dvd_q[k][DIV_W-2:0], ge[k]};
          end
          dit_q <= dit_q + 6'd1;
          if (dit_q == 6'(DIV_W - 1)) begin
            state_q <= S_MERGE;
          end
        end
        S_MERGE: begin
          res_valid_q <= 1'b1;
          status_q    <= ST_MERGED;
          slot_q      <= 6'(idx_q);
          lx_q        <= new_x[31:0];
          ly_q        <= new_y[31:0];
          cnt_q       <= n_new;
          state_q     <= S_IDLE;
        end
        S_MISS: begin
          res_valid_q <= 1'b1;
          lx_q        <= posx_q;
          ly_q        <= posy_q;
          if (used_q < UW'(CAPACITY)) begin
            status_q <= ST_INSERTED;
            slot_q   <= 6'(used_q);
            cnt_q    <= 16'd1;
            used_q   <= used_q + UW'(1);
          end else begin
            status_q <= ST_DROPPED;
            slot_q   <= '0;
            cnt_q    <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (skip_q || invalid_i) |=> result_valid_o && status_o == ST_SKIPPED)
    else $error("skipped item did not answer in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(CAPACITY))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_MERGE || state_q == S_MISS))
    else $error("table write outside update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_SKIPPED |-> slot_o == '0 && sample_count_o == '0)
    else $error("skipped result carries data");

endmodule
`default_nettype wire
